### hw/rtl/http_request_line_parser_macros.svh
// Assertion macros shared by the checker of the request line parser.
// Each macro expects clk and rst to be visible where it is used.
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

// Checked only outside reset.
`define HRLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hrlp check failed");

// Checked during reset as well.
`define HRLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hrlp reset check failed");

`endif

### hw/rtl/hrlp_pkg.sv
// Types, constants and byte-classification functions of the request line parser.
// Used by the top level, the parse step, the result register and the checker; depends on nothing.
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam int MAX_LINE_DEF = 4096;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_UNKNOWN_METHOD = 3'd1;
  localparam logic [2:0] ST_ENDS_EARLY     = 3'd2;
  localparam logic [2:0] ST_NOT_HTTP       = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG       = 3'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [3:0] {
    PH_SKIP_M,
    PH_METHOD,
    PH_SKIP_U,
    PH_URI,
    PH_SKIP_V,
    PH_PREFIX,
    PH_MAJ_WS,
    PH_MAJOR,
    PH_DOT,
    PH_MIN_WS,
    PH_MINOR,
    PH_DONE
  } phase_t;

  // Names left-justified in 64 bits; character k sits at [8*(7-k) +: 8].
  localparam logic [63:0] METHOD_NAME [8] = '{
    {"OPTIONS", 8'h00},
    {"GET", 40'h0},
    {"HEAD", 32'h0},
    {"POST", 32'h0},
    {"PUT", 40'h0},
    {"DELETE", 16'h0},
    {"TRACE", 24'h0},
    {"CONNECT", 8'h00}
  };
  localparam logic [3:0] METHOD_LEN [8] = '{4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7};
  localparam logic [31:0] HTTP_WORD = "HTTP";

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  cand;
    logic [3:0]  tidx;
    logic [11:0] uri_begin;
    logic [12:0] uri_count;
    logic [3:0]  pok;
    logic [15:0] major;
    logic [15:0] minor;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:     PH_SKIP_M,
    cand:      8'hFF,
    tidx:      4'd0,
    uri_begin: 12'd0,
    uri_count: 13'd0,
    pok:       4'hF,
    major:     16'd0,
    minor:     16'd0
  };

  typedef struct packed {
    logic [2:0]  method_code;
    logic [11:0] uri_offset;
    logic [12:0] uri_bytes;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic [2:0]  status;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Methods whose full name equals the token read so far.
  function automatic logic [7:0] exact_mask(input logic [7:0] cand, input logic [3:0] tidx);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = cand[i] && (METHOD_LEN[i] == tidx);
    end
    return m;
  endfunction

  // Methods still matching after byte b at position tidx.
  function automatic logic [7:0] match_mask(input logic [7:0] cand, input logic [3:0] tidx,
                                            input logic [7:0] b);
    logic [7:0] m;
    logic [2:0] k;
    m = '0;
    k = tidx[2:0];
    for (int i = 0; i < 8; i++) begin
      m[i] = cand[i] && (tidx < METHOD_LEN[i]) && (METHOD_NAME[i][8*(7-k) +: 8] == b);
    end
    return m;
  endfunction

  function automatic logic [2:0] first_set(input logic [7:0] cand);
    logic [2:0] c;
    c = '0;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) c = 3'(i);
    end
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [1:0] k);
    return HTTP_WORD[8*(3-k) +: 8];
  endfunction

  // Status for a request that ends with no result given yet.
  function automatic logic [2:0] end_status(input parse_state_t s);
    logic [2:0] r;
    case (s.phase)
      PH_SKIP_M: r = ST_UNKNOWN_METHOD;
      PH_METHOD: r = (exact_mask(s.cand, s.tidx) != 8'h00) ? ST_ENDS_EARLY : ST_UNKNOWN_METHOD;
      PH_SKIP_U, PH_URI, PH_SKIP_V: r = ST_ENDS_EARLY;
      PH_PREFIX: begin
        if (s.tidx == 4'd0) r = ST_ENDS_EARLY;
        else if (s.tidx == 4'd4 && s.pok == 4'hF) r = ST_BAD_VERSION;
        else r = ST_NOT_HTTP;
      end
      PH_MINOR: r = ST_OK;
      default: r = ST_BAD_VERSION;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/http_request_line_parser.sv
// Top level of the HTTP request line parser: input register, parse step, result register.
// Depends on hrlp_pkg, hrlp_in_reg, hrlp_step and hrlp_out_reg.
//
//   channel  direction  handshake            word
//   in       sink       in_valid/in_stall    data_byte, final_byte
//   out      source     out_valid/out_stall  method_code .. status
//
// One byte per cycle sustained while the result is not stalled; a byte is parsed once it sits in the
// input register and the result register is free, and any result word it yields is on the outputs from that same edge.
// The per-byte step between the input register and the parser state sets the clock rate.
// Reset (rst, synchronous) empties both registers and puts the parser at the request start.
// A stalled result blocks the parse step; one more byte waits in the input register and in_stall is raised.
`timescale 1ns / 1ps

module http_request_line_parser #(
  parameter int MAX_LINE = hrlp_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  method_code,
  output logic [11:0] uri_offset,
  output logic [12:0] uri_bytes,
  output logic [15:0] major_version,
  output logic [15:0] minor_version,
  output logic [2:0]  status
);

  logic              held_valid, held_last, advance, out_free, res_valid;
  logic [7:0]        held_byte;
  hrlp_pkg::result_t res, out_res;

  // advance the parser only when the result register can take what it gives
  assign advance = held_valid && out_free;

  hrlp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  hrlp_step #(
    .MAX_LINE (MAX_LINE)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_in   (held_byte),
    .last_in   (held_last),
    .res_valid (res_valid),
    .res       (res)
  );

  hrlp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (advance && res_valid),
    .load_res   (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .held       (out_res)
  );

  assign method_code   = out_res.method_code;
  assign uri_offset    = out_res.uri_offset;
  assign uri_bytes     = out_res.uri_bytes;
  assign major_version = out_res.major_version;
  assign minor_version = out_res.minor_version;
  assign status        = out_res.status;

endmodule

### hw/rtl/hrlp_in_reg.sv
// Input register of the request line parser: holds one byte word until the parser takes it.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps

module hrlp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held_byte <= data_byte;
      held_last <= final_byte;
    end
  end

endmodule

### hw/rtl/hrlp_step.sv
// Parser state register and the one-byte step logic of the request line parser.
// Depends on hrlp_pkg for the state and result types and the byte tables.
`timescale 1ns / 1ps

module hrlp_step #(
  parameter int MAX_LINE = hrlp_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output logic              res_valid,
  output hrlp_pkg::result_t res
);

  localparam int PW = $clog2(MAX_LINE + 1);

  hrlp_pkg::parse_state_t st, st_next, s;
  logic [PW-1:0]          pos, pos_next, pos_inc;
  hrlp_pkg::phase_t       ph;
  logic                   sp, dig, hit, too_long, ovf;
  logic [2:0]             status;
  logic [7:0]             m;
  logic [15:0]            acc;
  logic [19:0]            sum;
  logic [31:0]            pos_wide;

  assign sp       = hrlp_pkg::is_space(byte_in);
  assign dig      = hrlp_pkg::is_digit(byte_in);
  assign too_long = pos >= PW'(MAX_LINE);
  assign pos_wide = 32'(pos);

  // One decimal digit step on whichever number is being read.
  assign acc = (st.phase == hrlp_pkg::PH_MINOR) ? st.minor : st.major;
  assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, byte_in[3:0]};
  assign ovf = |sum[19:16];

  always_comb begin
    ph = st.phase;
    if (ph == hrlp_pkg::PH_SKIP_M && !sp) ph = hrlp_pkg::PH_METHOD;
    if (ph == hrlp_pkg::PH_SKIP_V && !sp) ph = hrlp_pkg::PH_PREFIX;
    s       = st;
    s.phase = ph;
    hit     = 1'b0;
    status  = hrlp_pkg::ST_OK;
    pos_inc = pos;
    m       = '0;
    if (st.phase != hrlp_pkg::PH_DONE) begin
      if (too_long) begin
        s      = st;
        hit    = 1'b1;
        status = hrlp_pkg::ST_TOO_LONG;
      end else begin
        pos_inc = pos + PW'(1);
        case (ph)
          hrlp_pkg::PH_METHOD: begin
            if (sp) begin
              m = hrlp_pkg::exact_mask(st.cand, st.tidx);
              if (m == 8'h00) begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_UNKNOWN_METHOD;
              end else begin
                s.cand  = m;
                s.phase = hrlp_pkg::PH_SKIP_U;
              end
            end else begin
              m      = hrlp_pkg::match_mask(st.cand, st.tidx, byte_in);
              s.cand = m;
              if (st.tidx != 4'hF) s.tidx = st.tidx + 4'd1;
              if (m == 8'h00) begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_UNKNOWN_METHOD;
              end
            end
          end
          hrlp_pkg::PH_SKIP_U: begin
            if (!sp) begin
              s.uri_begin = pos_wide[11:0];
              s.uri_count = 13'd1;
              s.phase     = hrlp_pkg::PH_URI;
            end
          end
          hrlp_pkg::PH_URI: begin
            if (sp) begin
              s.phase = hrlp_pkg::PH_SKIP_V;
              s.tidx  = 4'd0;
              s.pok   = 4'hF;
            end else begin
              s.uri_count = st.uri_count + 13'd1;
            end
          end
          hrlp_pkg::PH_PREFIX: begin
            if (byte_in == hrlp_pkg::CH_SLASH) begin
              if (st.tidx == 4'd4 && st.pok == 4'hF) begin
                s.phase = hrlp_pkg::PH_MAJ_WS;
              end else begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_NOT_HTTP;
              end
            end else if (st.tidx >= 4'd4) begin
              hit    = 1'b1;
              status = hrlp_pkg::ST_ENDS_EARLY;
            end else begin
              if (hrlp_pkg::http_char(st.tidx[1:0]) != byte_in) begin
                s.pok[st.tidx[1:0]] = 1'b0;
              end
              s.tidx = st.tidx + 4'd1;
            end
          end
          hrlp_pkg::PH_MAJ_WS, hrlp_pkg::PH_MIN_WS: begin
            if (!sp) begin
              if (!dig) begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_BAD_VERSION;
              end else if (ph == hrlp_pkg::PH_MAJ_WS) begin
                s.major = {12'h000, byte_in[3:0]};
                s.phase = hrlp_pkg::PH_MAJOR;
              end else begin
                s.minor = {12'h000, byte_in[3:0]};
                s.phase = hrlp_pkg::PH_MINOR;
              end
            end
          end
          hrlp_pkg::PH_MAJOR: begin
            if (dig) begin
              if (ovf) begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_BAD_VERSION;
              end else begin
                s.major = sum[15:0];
              end
            end else if (byte_in == hrlp_pkg::CH_DOT) begin
              s.phase = hrlp_pkg::PH_MIN_WS;
            end else if (sp) begin
              s.phase = hrlp_pkg::PH_DOT;
            end else begin
              hit    = 1'b1;
              status = hrlp_pkg::ST_BAD_VERSION;
            end
          end
          hrlp_pkg::PH_DOT: begin
            if (!sp) begin
              if (byte_in == hrlp_pkg::CH_DOT) begin
                s.phase = hrlp_pkg::PH_MIN_WS;
              end else begin
                hit    = 1'b1;
                status = hrlp_pkg::ST_BAD_VERSION;
              end
            end
          end
          hrlp_pkg::PH_MINOR: begin
            hit = 1'b1;
            if (dig) begin
              if (ovf) begin
                status = hrlp_pkg::ST_BAD_VERSION;
              end else begin
                hit     = 1'b0;
                s.minor = sum[15:0];
              end
            end else begin
              status = hrlp_pkg::ST_OK;
            end
          end
          default: begin
            // whitespace before the method or the version: nothing to record
          end
        endcase
      end
      if (!hit && last_in) begin
        hit    = 1'b1;
        status = hrlp_pkg::end_status(s);
      end
    end
  end

  always_comb begin
    res.method_code   = (s.phase >= hrlp_pkg::PH_SKIP_U) ? hrlp_pkg::first_set(s.cand) : 3'd0;
    res.uri_offset    = s.uri_begin;
    res.uri_bytes     = s.uri_count;
    res.major_version = s.major;
    res.minor_version = s.minor;
    res.status        = status;
    res_valid         = hit;
  end

  always_comb begin
    st_next  = s;
    pos_next = pos_inc;
    if (hit) st_next.phase = hrlp_pkg::PH_DONE;
    // the last-byte mark returns the parser to its idle state
    if (last_in) begin
      st_next  = hrlp_pkg::PARSE_RESET;
      pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= hrlp_pkg::PARSE_RESET;
      pos <= '0;
    end else if (advance) begin
      st  <= st_next;
      pos <= pos_next;
    end
  end

endmodule

### hw/rtl/hrlp_out_reg.sv
// Result register of the request line parser: holds one result word until it is taken.
// Depends on hrlp_pkg for the result type.
`timescale 1ns / 1ps

module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  hrlp_pkg::result_t load_res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output hrlp_pkg::result_t held
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      held <= load_res;
    end
  end

endmodule

### hw/rtl/hrlp_checker.sv
// Port-level checks on the request line parser, bound to its top level.
// Depends on hrlp_pkg and http_request_line_parser_macros.svh.
`timescale 1ns / 1ps
`include "http_request_line_parser_macros.svh"

module hrlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  method_code,
  input logic [12:0] uri_bytes,
  input logic [2:0]  status
);

  // the result register comes out of reset empty
  `HRLP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

  `HRLP_ASSERT(a_status_range, out_valid |-> status <= hrlp_pkg::ST_TOO_LONG)

  // a method failure is decided before any URI is seen
  `HRLP_ASSERT(a_unknown_no_uri, out_valid && status == hrlp_pkg::ST_UNKNOWN_METHOD |-> method_code == 3'd0 && uri_bytes == 13'd0)

  // hold a stalled result word
  `HRLP_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(uri_bytes))

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);
